FILE: rtl/core/assert_macros.svh
// Assertion macros for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked assertion with asynchronous reset disable.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Plain implication checked every edge.
`define ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`endif

FILE: rtl/core/smx_pkg.sv
// Package: constants, types and the exp table for the softmax decoder.
package smx_pkg;
  localparam int unsigned NumClassesDefault = 5;
  localparam int unsigned ExpDepthDefault   = 256;
  localparam int unsigned ScoreW  = 24;
  localparam int unsigned ProbW   = 17;
  localparam int unsigned PmW     = 10;
  localparam int unsigned IdxW    = 4;
  localparam int unsigned SumW    = 28;
  localparam int unsigned EsumW   = 21;
  localparam logic [PmW-1:0] ThreshReset = 10'd500;
  localparam logic [ProbW-1:0] ProbOne = 17'd65536;

  // Long division, only used at elaboration to build the exp table and E1.
  function automatic longint unsigned long_div(input longint unsigned num,
                                               input longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = 64'd0;
    rem = 64'd0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // exp(-num/depth) in Q2.30 by the series truncated after the 20th power, at elaboration.
  function automatic logic [31:0] exp_series_q30(input longint unsigned num,
                                                 input longint unsigned depth);
    longint unsigned term;
    longint unsigned pos;
    longint unsigned neg;
    term = 64'd1073741824;
    pos  = 64'd1073741824;
    neg  = 64'd0;
    for (int i = 1; i <= 20; i++) begin
      term = long_div(term * num, depth * longint'(i));
      if (i[0]) neg += term;
      else pos += term;
    end
    return (pos >= neg) ? 32'(pos - neg) : 32'd0;
  endfunction

  typedef enum logic [7:0] {
    ST_LOAD  = 8'b0000_0001,
    ST_EXP   = 8'b0000_0010,
    ST_EMUL  = 8'b0000_0100,
    ST_EACC  = 8'b0000_1000,
    ST_DIV   = 8'b0001_0000,
    ST_PICK  = 8'b0010_0000,
    ST_CONF  = 8'b0100_0000,
    ST_EMIT  = 8'b1000_0000
  } state_e;

  typedef struct packed {
    logic       start;
    logic [47:0] dividend;
    logic [EsumW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic       busy;
    logic       done;
    logic [31:0] quot;
  } div_rsp_t;
endpackage

FILE: rtl/core/softmax_top1_classifier_decode.sv
// Top level: top-1 classifier decode with optional fixed-point softmax.
// channel | dir | signals                         | carries
// in      | in  | in_valid_i/in_ready_o, score_i  | one class score per beat
// cfg     | in  | cfg_valid_i/cfg_ready_o, cfg_data_i | uncertain threshold
// out     | out | out_valid_o/out_ready_i, fields  | one class result per beat
// Loading accepts one score beat per cycle. After the last score, a pick pass over
// the N classes and a confidence step come before the N result beats. With softmax,
// each class first runs the exp states on the shared exp multiplier, with n multiply
// steps (n = integer part of max - score, capped at 255, cut short once the value
// reaches zero), then each class is divided in turn on the shared divider. Reset
// clears control state only. Emission stalls on out_ready_i; no input is taken then.
module softmax_top1_classifier_decode
  import smx_pkg::*;
#(
  parameter int unsigned NUM_CLASSES     = NumClassesDefault,
  parameter int unsigned EXP_TABLE_DEPTH = ExpDepthDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [ScoreW-1:0] score_i,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [PmW-1:0]           cfg_data_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [IdxW-1:0]          class_index_o,
  output logic [PmW-1:0]           score_permille_o,
  output logic [IdxW-1:0]          pred_class_o,
  output logic [PmW-1:0]           pred_conf_pm_o,
  output logic                     uncertain_o,
  output logic                     softmax_applied_o,
  output logic                     last_o
);
`include "assert_macros.svh"
  localparam int unsigned CW = $clog2(NUM_CLASSES);
  localparam int unsigned KW = $clog2(EXP_TABLE_DEPTH + 1);
  localparam logic [31:0] E1 = exp_series_q30(64'(EXP_TABLE_DEPTH),
                                              64'(EXP_TABLE_DEPTH));
  localparam logic [CW-1:0] LastCls = CW'(NUM_CLASSES - 1);

  logic [31:0] exp_tab [EXP_TABLE_DEPTH+1];
  for (genvar g = 0; g <= EXP_TABLE_DEPTH; g++) begin : g_tab
    assign exp_tab[g] = exp_series_q30(64'(g), 64'(EXP_TABLE_DEPTH));
  end

  state_e state_q, state_d;
  logic signed [ScoreW-1:0] score_q [NUM_CLASSES];
  logic [ProbW-1:0]         prob_q  [NUM_CLASSES];
  logic [CW-1:0]   cnt_q, cnt_d;
  logic signed [SumW-1:0] rsum_q;
  logic signed [ScoreW-1:0] rmax_q;
  logic            oor_q, sm_q;
  logic [PmW-1:0]  thr_q;
  logic [EsumW-1:0] esum_q;
  logic [31:0]     r_q;
  logic [7:0]      n_q;
  logic [ProbW-1:0] best_p_q;
  logic [CW-1:0]   best_i_q;
  logic [PmW-1:0]  conf_q;
  logic            in_acc, out_acc;
  div_req_t        dreq;
  div_rsp_t        drsp;

  smx_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  // Sum test: sum*100 vs 98/102 * 65536.
  logic signed [SumW+7:0] sum_new, sum100;
  logic signed [ScoreW-1:0] max_new;
  logic oor_new, need_sm;
  assign sum_new = (SumW+8)'(rsum_q) + (SumW+8)'(score_i);
  assign sum100  = (SumW+8)'(sum_new * 100);
  assign max_new = (score_i > rmax_q) ? score_i : rmax_q;
  assign oor_new = oor_q | score_i[ScoreW-1] | (score_i > 24'sd65536);
  assign need_sm = oor_new | (sum100 < 36'sd6422528) | (sum100 > 36'sd6684672);

  // Exp front end: x = max - score, split into n and table index k.
  logic [ScoreW:0] x;
  logic [KW-1:0]   k;
  logic [63:0]     prod;
  logic [16:0]     e16;
  logic [ProbW-1:0] clamp;
  logic [27:0]     pm_full;
  assign x    = (ScoreW+1)'(signed'(rmax_q)) - (ScoreW+1)'(signed'(score_q[cnt_q]));
  assign k    = KW'((({16'd0, x[15:0]} * 32'(EXP_TABLE_DEPTH)) + 32'd32768) >> 16);
  assign prod = 64'(r_q) * 64'(E1);
  assign e16  = 17'((33'(r_q) + 33'd8192) >> 14);
  assign clamp = (prob_q[cnt_q] > ProbOne) ? ProbOne : prob_q[cnt_q];
  assign pm_full = (28'(best_p_q) * 28'd1000 + 28'd32768) >> 16;

  logic [27:0] out_pm;
  assign out_pm = (28'(prob_q[cnt_q]) * 28'd1000 + 28'd32768) >> 16;

  assign in_ready_o  = (state_q == ST_LOAD);
  assign in_acc      = in_valid_i & in_ready_o;
  assign out_valid_o = (state_q == ST_EMIT);
  assign out_acc     = out_valid_o & out_ready_i;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    state_d = state_q; cnt_d = cnt_q;
    dreq.start = 1'b0;
    dreq.dividend = {15'd0, prob_q[cnt_q], 16'd0} + 48'(esum_q >> 1);
    dreq.divisor  = esum_q;
    case (state_q)
      ST_LOAD: if (in_acc) begin
        if (cnt_q == LastCls) begin
          cnt_d = '0;
          state_d = need_sm ? ST_EXP : ST_PICK;
        end else cnt_d = cnt_q + 1'b1;
      end
      ST_EXP:  state_d = ST_EMUL;
      ST_EMUL: if (n_q == 8'd0 || r_q == 32'd0) state_d = ST_EACC;
      ST_EACC: begin
        if (cnt_q == LastCls) begin cnt_d = '0; state_d = ST_DIV; dreq.start = 1'b1; end
        else begin cnt_d = cnt_q + 1'b1; state_d = ST_EXP; end
      end
      ST_DIV: if (drsp.done) begin
        if (cnt_q == LastCls) begin cnt_d = '0; state_d = ST_PICK; end
        else begin cnt_d = cnt_q + 1'b1; dreq.start = 1'b1; end
      end
      ST_PICK: begin
        if (cnt_q == LastCls) begin cnt_d = '0; state_d = ST_CONF; end
        else cnt_d = cnt_q + 1'b1;
      end
      ST_CONF: state_d = ST_EMIT;
      ST_EMIT: if (out_acc) begin
        if (cnt_q == LastCls) begin cnt_d = '0; state_d = ST_LOAD; end
        else cnt_d = cnt_q + 1'b1;
      end
      default: state_d = ST_LOAD;
    endcase
    if (state_q == ST_DIV && drsp.done && cnt_q != LastCls) begin
      dreq.dividend = {15'd0, prob_q[cnt_q + 1'b1], 16'd0} + 48'(esum_q >> 1);
    end else if (state_q == ST_EACC) begin
      dreq.dividend = {15'd0, prob_q[0], 16'd0} + 48'((esum_q + EsumW'(e16)) >> 1);
      dreq.divisor  = esum_q + EsumW'(e16);
      if (cnt_q != LastCls) dreq.start = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD; cnt_q <= '0; rsum_q <= '0;
      rmax_q <= {1'b1, {(ScoreW-1){1'b0}}}; oor_q <= 1'b0; sm_q <= 1'b0;
      thr_q <= ThreshReset;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d;
      if (cfg_valid_i) thr_q <= cfg_data_i;
      if (in_acc) begin
        if (cnt_q == LastCls) begin
          rsum_q <= '0; oor_q <= 1'b0; sm_q <= need_sm;
        end else begin
          rsum_q <= SumW'(sum_new); oor_q <= oor_new;
        end
        rmax_q <= max_new;
      end else if (out_acc && cnt_q == LastCls) begin
        rmax_q <= {1'b1, {(ScoreW-1){1'b0}}};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      score_q[cnt_q] <= score_i;
      prob_q[cnt_q]  <= ProbW'(unsigned'(score_i));
      if (cnt_q == LastCls) esum_q <= '0;
    end
    case (state_q)
      ST_EXP: begin
        r_q <= exp_tab[k];
        n_q <= (x[ScoreW:16] > 9'd255) ? 8'd255 : x[23:16];
      end
      ST_EMUL: if (n_q != 8'd0 && r_q != 32'd0) begin
        r_q <= 32'(prod >> 30); n_q <= n_q - 8'd1;
      end
      ST_EACC: begin
        prob_q[cnt_q] <= e16;
        esum_q <= esum_q + EsumW'(e16);
      end
      ST_DIV: if (drsp.done) prob_q[cnt_q] <= ProbW'(drsp.quot);
      ST_PICK: begin
        prob_q[cnt_q] <= clamp;
        if (cnt_q == '0) begin best_p_q <= clamp; best_i_q <= '0; end
        else if (clamp > best_p_q) begin best_p_q <= clamp; best_i_q <= cnt_q; end
      end
      ST_CONF: conf_q <= PmW'(pm_full);
      default: ;
    endcase
  end

  logic is_last;
  assign is_last = (cnt_q == LastCls);
  assign class_index_o         = IdxW'(cnt_q);
  assign score_permille_o      = PmW'(out_pm);
  assign pred_class_o          = is_last ? IdxW'(best_i_q) : '0;
  assign pred_conf_pm_o        = is_last ? conf_q : '0;
  assign uncertain_o           = is_last ? (conf_q < thr_q) : 1'b0;
  assign softmax_applied_o     = sm_q;
  assign last_o                = is_last;

  `ASSERT_IMP(a_no_in_busy, clk_i, rst_ni, state_q != ST_LOAD, !in_ready_o, "input taken busy")
  `ASSERT_IMP(a_div_only, clk_i, rst_ni, drsp.busy, state_q == ST_DIV, "divider out of phase")
  `ASSERT_CLK(a_onehot, clk_i, rst_ni, $onehot(state_q), "state not one-hot")
endmodule

FILE: rtl/core/smx_div.sv
// Shared restoring divider, one quotient bit per cycle.
module smx_div
  import smx_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);
  localparam int unsigned QW = 32;
  logic [QW-1:0] quot_q, quot_d;
  logic [47:0]   rem_q, rem_d;
  logic [47:0]   num_q, num_d;
  logic [EsumW-1:0] den_q, den_d;
  logic [5:0]    cnt_q, cnt_d;
  logic          busy_q, busy_d, done_q, done_d;
  logic [48:0]   trial;

  always_comb begin
    quot_d = quot_q; rem_d = rem_q; num_d = num_q; den_d = den_q;
    cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0;
    trial = {rem_q, num_q[47]};
    if (req_i.start) begin
      num_d = req_i.dividend << 16;
      rem_d = {32'd0, req_i.dividend[47:32]};
      den_d = req_i.divisor; quot_d = '0;
      cnt_d = 6'd32; busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= 49'(den_q)) begin
        rem_d  = 48'(trial - 49'(den_q));
        quot_d = {quot_q[QW-2:0], 1'b1};
      end else begin
        rem_d  = trial[47:0];
        quot_d = {quot_q[QW-2:0], 1'b0};
      end
      num_d = num_q << 1;
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    quot_q <= quot_d; rem_q <= rem_d; num_q <= num_d; den_q <= den_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;
endmodule
